FILE: src/itdt_pkg.sv
// Shared constants, codes and helpers for the interval timer.
// No dependencies; compiled first.
package itdt_pkg;

  localparam int unsigned DIV_PERIOD = 64;   // ticks per divider step, 1..128

  localparam int unsigned DIV_PS_W = 7;      // divider prescaler width
  localparam int unsigned CNT_PS_W = 9;      // counter prescaler width
  localparam int unsigned BYTE_W   = 8;

  typedef logic [1:0]          opcode_t;
  typedef logic [1:0]          reg_sel_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [DIV_PS_W-1:0] div_ps_t;
  typedef logic [CNT_PS_W-1:0] cnt_ps_t;

  // request opcodes
  localparam opcode_t OP_TICK  = 2'd0;
  localparam opcode_t OP_READ  = 2'd1;
  localparam opcode_t OP_WRITE = 2'd2;

  // register map
  localparam reg_sel_t REG_DIV  = 2'd0;
  localparam reg_sel_t REG_CNT  = 2'd1;
  localparam reg_sel_t REG_MOD  = 2'd2;
  localparam reg_sel_t REG_CTRL = 2'd3;

  localparam int unsigned CTRL_EN_BIT = 2;
  localparam byte_t       CNT_MAX     = 8'hFF;

  localparam logic [DIV_PS_W:0] DIV_PERIOD_C = (DIV_PS_W+1)'(DIV_PERIOD);

  // counter prescaler period for each period select code
  function automatic logic [CNT_PS_W:0] period_ticks(input logic [1:0] sel);
    logic [CNT_PS_W:0] ticks;
    unique case (sel)
      2'd0: ticks = (CNT_PS_W+1)'(256);
      2'd1: ticks = (CNT_PS_W+1)'(4);
      2'd2: ticks = (CNT_PS_W+1)'(16);
      2'd3: ticks = (CNT_PS_W+1)'(64);
      default: ticks = (CNT_PS_W+1)'(256);
    endcase
    return ticks;
  endfunction

endpackage

FILE: src/itdt_in_if.sv
// Request channel of the interval timer: valid/ready plus request payload.
// Depends on itdt_pkg.
interface itdt_in_if;
  logic               valid;
  logic               ready;
  itdt_pkg::opcode_t  opcode;
  itdt_pkg::reg_sel_t reg_select;
  itdt_pkg::byte_t    write_data;

  modport source (output valid, output opcode, output reg_select, output write_data,
                  input ready);
  modport sink   (input valid, input opcode, input reg_select, input write_data,
                  output ready);
endinterface

FILE: src/itdt_out_if.sv
// Result channel of the interval timer: valid/ready plus result payload.
// Depends on itdt_pkg.
interface itdt_out_if;
  logic            valid;
  logic            ready;
  itdt_pkg::byte_t read_data;
  logic            overflow_irq;

  modport source (output valid, output read_data, output overflow_irq, input ready);
  modport sink   (input valid, input read_data, input overflow_irq, output ready);
endinterface

FILE: src/interval_timer_div_tima.sv
// Interval timer top level: divider, prescaled 8-bit counter with reload.
// Depends on itdt_pkg, itdt_in_if, itdt_out_if.
//
// Usage:
//   in_ch carries one request per handshake: a tick, a register read or a
//   register write (reg_select 0 divider, 1 counter, 2 modulo, 3 control).
//   out_ch returns exactly one result per request, in order: read_data
//   holds the register on a read (zero otherwise), overflow_irq pulses on
//   the tick that wrapped the counter from 0xFF and reloaded it.
//   Latency: the result is valid the cycle after the request is accepted.
//   Throughput: one request per clock barring back-pressure. The timer
//   state updates in the accept cycle, so a read right after a tick or
//   write sees its effect. The single result register is the only buffer:
//   in_ch.ready is high when that register is empty or being drained this
//   cycle, so a stalled receiver holds the pending result and
//   back-pressures requests; no request is lost or repeated.
//   Reset (rst_n low, synchronous) clears all timer registers and the
//   result valid flag.
module interval_timer_div_tima (
  input  logic clk,
  input  logic rst_n,
  itdt_in_if.sink    in_ch,
  itdt_out_if.source out_ch
);
  import itdt_pkg::*;

  // timer state
  div_ps_t    div_prescale_r, div_prescale_nxt;
  byte_t      div_value_r, div_value_nxt;
  cnt_ps_t    count_prescale_r, count_prescale_nxt;
  byte_t      count_value_r, count_value_nxt;
  byte_t      reload_value_r, reload_value_nxt;
  byte_t      control_value_r, control_value_nxt;
  logic [1:0] period_select_r, period_select_nxt;

  // result register
  logic  out_valid_r;
  byte_t read_data_r, read_data_nxt;
  logic  irq_r, irq_nxt;

  logic in_fire;
  logic [DIV_PS_W:0] div_ps_inc;
  logic [CNT_PS_W:0] cnt_ps_inc;

  // result slot frees up when empty or drained this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign div_ps_inc = {1'b0, div_prescale_r} + 1'b1;
  assign cnt_ps_inc = {1'b0, count_prescale_r} + 1'b1;

  always_comb begin
    div_prescale_nxt   = div_prescale_r;
    div_value_nxt      = div_value_r;
    count_prescale_nxt = count_prescale_r;
    count_value_nxt    = count_value_r;
    reload_value_nxt   = reload_value_r;
    control_value_nxt  = control_value_r;
    period_select_nxt  = period_select_r;
    read_data_nxt      = '0;
    irq_nxt            = 1'b0;

    unique case (in_ch.opcode)
      OP_TICK: begin
        // divider advances every DIV_PERIOD ticks
        if (div_ps_inc >= DIV_PERIOD_C) begin
          div_prescale_nxt = '0;
          div_value_nxt    = div_value_r + 1'b1;
        end else begin
          div_prescale_nxt = div_ps_inc[DIV_PS_W-1:0];
        end
        // counter runs only while enabled; prescaler holds otherwise
        if (control_value_r[CTRL_EN_BIT]) begin
          if (cnt_ps_inc >= period_ticks(period_select_r)) begin
            count_prescale_nxt = '0;
            if (count_value_r == CNT_MAX) begin
              count_value_nxt = reload_value_r;
              irq_nxt         = 1'b1;
            end else begin
              count_value_nxt = count_value_r + 1'b1;
            end
          end else begin
            count_prescale_nxt = cnt_ps_inc[CNT_PS_W-1:0];
          end
        end
      end
      OP_READ: begin
        unique case (in_ch.reg_select)
          REG_DIV:  read_data_nxt = div_value_r;
          REG_CNT:  read_data_nxt = count_value_r;
          REG_MOD:  read_data_nxt = reload_value_r;
          REG_CTRL: read_data_nxt = control_value_r;
          default:  read_data_nxt = control_value_r;
        endcase
      end
      OP_WRITE: begin
        unique case (in_ch.reg_select)
          REG_DIV: begin
            // any divider write clears it and its prescaler
            div_value_nxt    = '0;
            div_prescale_nxt = '0;
          end
          REG_CNT: count_value_nxt  = in_ch.write_data;
          REG_MOD: reload_value_nxt = in_ch.write_data;
          REG_CTRL: begin
            control_value_nxt = in_ch.write_data;
            // new period latched only by a write that also enables
            if (in_ch.write_data[CTRL_EN_BIT]) begin
              period_select_nxt = in_ch.write_data[1:0];
            end
          end
          default: ;
        endcase
      end
      default: ;  // unused opcode: no effect, zero result
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_prescale_r   <= '0;
      div_value_r      <= '0;
      count_prescale_r <= '0;
      count_value_r    <= '0;
      reload_value_r   <= '0;
      control_value_r  <= '0;
      period_select_r  <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (in_fire) begin
        div_prescale_r   <= div_prescale_nxt;
        div_value_r      <= div_value_nxt;
        count_prescale_r <= count_prescale_nxt;
        count_value_r    <= count_value_nxt;
        reload_value_r   <= reload_value_nxt;
        control_value_r  <= control_value_nxt;
        period_select_r  <= period_select_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      read_data_r <= read_data_nxt;
      irq_r       <= irq_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = read_data_r;
  assign out_ch.overflow_irq = irq_r;

  // checks
  a_irq_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.opcode != OP_TICK) |=> !irq_r)
    else $error("interrupt raised by a non-tick request");

  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.opcode != OP_READ) |=> (read_data_r == '0))
    else $error("read data nonzero on a non-read request");

  a_div_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.opcode == OP_WRITE) && (in_ch.reg_select == REG_DIV)
    |=> (div_value_r == '0) && (div_prescale_r == '0))
    else $error("divider write did not clear divider");

  a_div_ps_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, div_prescale_r} < DIV_PERIOD_C)
    else $error("divider prescaler out of range");

  a_irq_reload: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && irq_nxt |=> irq_r && (count_value_r == reload_value_r))
    else $error("overflow did not reload the counter");

endmodule
